### rtl/core/lsp_pkg.sv
// Package with the shared constants, codes and types of the parity-removal stack.
`default_nettype none

package lsp_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CntW   = $clog2(Depth + 1);

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    CmdPush      = 2'd0,
    CmdPop       = 2'd1,
    CmdRemoveEven = 2'd2,
    CmdRemoveOdd = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StEmpty   = 2'd1,
    StNoMatch = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef struct packed {
    logic shift_down;
    logic pop;
    logic remove;
    logic want_odd;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/lifo_stack_parity_remove.sv
// Top level of the LIFO stack with removal of the topmost even or odd word.
// Each accepted command updates the cell row and its result word appears
// on the output register in the next cycle.
// Throughput is one command per cycle while no result word is held by out_stall_i.
// Reset clears the internal fill count and the output valid; the cell contents stay undefined.
`default_nettype none

module lifo_stack_parity_remove (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire          [1:0] cmd_i,
  input  wire signed  [31:0] value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic         [1:0] status_o,
  output logic signed [31:0] top_value_o,
  output logic               top_valid_o,
  output lsp_pkg::cnt_t      fill_count_o
);
  import lsp_pkg::*;

  cnt_t       count_q, count_d;
  logic       out_valid_q, out_valid_d;
  status_e    status_q, status_d;
  data_t      top_value_q, top_value_d;
  logic       top_valid_q;
  cnt_t       fill_q;
  logic       accept;
  logic       empty, full, found;
  cmd_e       cmd;
  cell_ctrl_t ctrl;

  data_t data_w [Depth];
  data_t next_w [Depth];
  logic  hit_w  [Depth+1];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cmd        = cmd_e'(cmd_i);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(Depth));
  assign hit_w[0]   = 1'b0;
  assign found      = hit_w[Depth];

  always_comb begin
    ctrl = '0;
    unique case (cmd)
      CmdPush: begin
        ctrl.shift_down = accept & ~full;
      end
      CmdPop: begin
        ctrl.pop = accept & ~empty;
      end
      CmdRemoveEven, CmdRemoveOdd: begin
        ctrl.remove   = accept;
        ctrl.want_odd = (cmd == CmdRemoveOdd);
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_comb begin
    status_d = StOk;
    count_d  = count_q;
    unique case (cmd)
      CmdPush: begin
        if (full) begin
          status_d = StFull;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CmdPop: begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CmdRemoveEven, CmdRemoveOdd: begin
        if (empty) begin
          status_d = StEmpty;
        end else if (!found) begin
          status_d = StNoMatch;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    data_t up_data;
    data_t down_data;
    logic  occupied;

    assign occupied = (count_q > CntW'(i));

    if (i == 0) begin : g_top
      assign up_data = data_t'(value_i);
    end else begin : g_mid
      assign up_data = data_w[i-1];
    end

    if (i == Depth - 1) begin : g_bottom
      assign down_data = data_w[i];
    end else begin : g_inner
      assign down_data = data_w[i+1];
    end

    lsp_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied),
      .hit_i       (hit_w[i]),
      .hit_o       (hit_w[i+1]),
      .up_data_i   (up_data),
      .down_data_i (down_data),
      .data_o      (data_w[i]),
      .data_next_o (next_w[i])
    );
  end

  assign top_value_d = (count_d != '0) ? next_w[0] : '0;

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      top_value_q <= top_value_d;
      top_valid_q <= (count_d != '0);
      fill_q      <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign top_value_o  = top_value_q;
  assign top_valid_o  = top_valid_q;
  assign fill_count_o = fill_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count exceeds the stack depth");

  a_accept_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted command produced no result word");

  a_hold_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !accept)
    else $error("command accepted while a result word is held");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StFull) |-> (fill_q == CntW'(Depth)))
    else $error("dropped push reported on a stack that is not full");

  a_top_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (top_valid_q == (fill_q != '0)))
    else $error("top valid disagrees with the fill count");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl.remove && found) |=> (count_q == $past(count_q) - 1'b1))
    else $error("successful removal did not shrink the stack");

endmodule

`default_nettype wire

### rtl/core/lsp_cell.sv
// One stack cell that holds a word and shifts toward or away from the top.
`default_nettype none

module lsp_cell (
  input  wire                 clk_i,
  input  lsp_pkg::cell_ctrl_t ctrl_i,
  input  wire                 occupied_i,
  input  wire                 hit_i,
  output logic                hit_o,
  input  lsp_pkg::data_t      up_data_i,
  input  lsp_pkg::data_t      down_data_i,
  output lsp_pkg::data_t      data_o,
  output lsp_pkg::data_t      data_next_o
);
  import lsp_pkg::*;

  data_t data_q;
  data_t data_d;
  logic  match;
  logic  shift_up;

  assign match    = (data_q[0] == ctrl_i.want_odd);
  assign hit_o    = hit_i | (ctrl_i.remove & occupied_i & match);
  assign shift_up = ctrl_i.pop | (ctrl_i.remove & hit_o);

  always_comb begin
    if (ctrl_i.shift_down) begin
      data_d = up_data_i;
    end else if (shift_up) begin
      data_d = down_data_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign data_next_o = data_d;

endmodule

`default_nettype wire
